@@ rtl/elevator_request_scheduler_core_defines.svh @@
// ----------------------------------------------------------------------------
// Elevator request scheduler assertion macros
// Concurrent assertion helpers; they compile away when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef ELEVATOR_REQUEST_SCHEDULER_CORE_DEFINES_SVH
`define ELEVATOR_REQUEST_SCHEDULER_CORE_DEFINES_SVH

`ifndef SYNTHESIS
// Assertion on an explicit clock and active-low reset.
`define ERS_ASSERT_CLK(lbl, clk_s, rstn_s, prop, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) prop) else $error(msg);
// Assertion on the block clock clk and reset rst_n.
`define ERS_ASSERT(lbl, prop, msg) \
  `ERS_ASSERT_CLK(lbl, clk, rst_n, prop, msg)
`else
`define ERS_ASSERT_CLK(lbl, clk_s, rstn_s, prop, msg)
`define ERS_ASSERT(lbl, prop, msg)
`endif

`endif

@@ rtl/ers_pkg.sv @@
// ----------------------------------------------------------------------------
// Elevator request scheduler package
// Field widths, item and mode codes, and the result type.
// ----------------------------------------------------------------------------
package ers_pkg;

  localparam int FLOOR_W        = 6;
  localparam int KIND_W         = 2;
  localparam int TIME_W         = 10;
  localparam int SPF_W          = 4;
  localparam int MODE_W         = 2;
  localparam int NUM_FLOORS_DEF = 64;

  localparam logic [SPF_W-1:0] SPF_RESET = SPF_W'(2);

  // transaction kinds
  localparam logic [KIND_W-1:0] KIND_TICK  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_REQ   = 2'd1;
  localparam logic [KIND_W-1:0] KIND_PLACE = 2'd2;

  // motion modes, also the direction field codes
  localparam logic [MODE_W-1:0] MODE_STILL = 2'd0;
  localparam logic [MODE_W-1:0] MODE_UP    = 2'd1;
  localparam logic [MODE_W-1:0] MODE_DOWN  = 2'd2;

  typedef struct packed {
    logic [MODE_W-1:0]  direction;
    logic [FLOOR_W-1:0] target_floor;
    logic [TIME_W-1:0]  time_left;
    logic [FLOOR_W-1:0] current_floor;
    logic               arrived;
  } result_t;

endpackage

@@ rtl/ers_req_if.sv @@
// ----------------------------------------------------------------------------
// Elevator request scheduler input channel
// Valid/ready channel carrying the item kind and floor.
// ----------------------------------------------------------------------------
interface ers_req_if;
  import ers_pkg::*;

  logic               valid;
  logic               ready;
  logic [KIND_W-1:0]  kind;
  logic [FLOOR_W-1:0] floor;

  modport source (output valid, output kind, output floor, input ready);
  modport sink   (input valid, input kind, input floor, output ready);
endinterface

@@ rtl/ers_rsp_if.sv @@
// ----------------------------------------------------------------------------
// Elevator request scheduler result channel
// Valid/ready channel carrying the car status after each transaction.
// ----------------------------------------------------------------------------
interface ers_rsp_if;
  import ers_pkg::*;

  logic               valid;
  logic               ready;
  logic [MODE_W-1:0]  direction;
  logic [FLOOR_W-1:0] target_floor;
  logic [TIME_W-1:0]  time_left;
  logic [FLOOR_W-1:0] current_floor;
  logic               arrived;

  modport source (output valid, output direction, output target_floor, output time_left,
                  output current_floor, output arrived, input ready);
  modport sink   (input valid, input direction, input target_floor, input time_left,
                  input current_floor, input arrived, output ready);
endinterface

@@ rtl/elevator_request_scheduler_core.sv @@
// ----------------------------------------------------------------------------
// Elevator request scheduler core
// Single-car LOOK scheduler: request bitmaps, target pick and travel timer.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch  : valid/ready input. Each transaction is a tick (one second), a
//            floor request, or a placement of the car at a floor.
//   out_ch : valid/ready result. Exactly one result per input transaction:
//            direction, target floor, ticks left, current floor, arrived.
//   cfg_we / cfg_wdata : seconds_per_floor, written while the block is idle.
// Latency: a result is valid the cycle after its input is accepted.
// Throughput: one transaction per cycle while out_ch.ready is high or the
//   result register is empty. The whole update (both priority encoders,
//   distance, 4x6 multiply, countdown) is combinational into state and result.
// Stall: the result register holds while out_ch.ready is low; in_ch.ready
//   follows out_ch.ready then, and is high whenever the register is empty.
// Reset: both request bitmaps cleared, car at floor 0, no travel, mode up,
//   seconds_per_floor = 2, result register empty.
// ----------------------------------------------------------------------------
`include "elevator_request_scheduler_core_defines.svh"

module elevator_request_scheduler_core #(
  parameter int NUM_FLOORS = ers_pkg::NUM_FLOORS_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  ers_req_if.sink                  in_ch,
  ers_rsp_if.source                out_ch,
  input  logic                     cfg_we,
  input  logic [ers_pkg::SPF_W-1:0] cfg_wdata
);
  import ers_pkg::*;

  localparam int FIDX_W = (NUM_FLOORS > 1) ? $clog2(NUM_FLOORS) : 1;
  localparam logic [FLOOR_W:0]  FLOOR_LIMIT = (FLOOR_W + 1)'(NUM_FLOORS);
  localparam logic [FIDX_W-1:0] TOP_FLOOR   = FIDX_W'(NUM_FLOORS - 1);

  // scheduler state
  logic [NUM_FLOORS-1:0] up_r, up_nxt;
  logic [NUM_FLOORS-1:0] down_r, down_nxt;
  logic [FIDX_W-1:0]     car_r, car_nxt;
  logic [FIDX_W-1:0]     head_r, head_nxt;
  logic [TIME_W-1:0]     travel_r, travel_nxt;
  logic [MODE_W-1:0]     mode_r, mode_nxt;
  logic [SPF_W-1:0]      spf_r;

  // result register
  logic    out_valid_r;
  result_t res_r, res_nxt;

  logic in_acc;
  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign in_acc      = in_ch.valid && in_ch.ready;

  // lowest pending up floor and highest pending down floor
  logic [FIDX_W-1:0] lo_up, hi_dn;
  always_comb begin
    lo_up = '0;
    for (int i = NUM_FLOORS - 1; i >= 0; i--) begin
      if (up_r[i]) lo_up = FIDX_W'(i);
    end
  end
  always_comb begin
    hi_dn = '0;
    for (int i = 0; i < NUM_FLOORS; i++) begin
      if (down_r[i]) hi_dn = FIDX_W'(i);
    end
  end

  // request floor decode
  logic              req_in_range;
  logic [FIDX_W-1:0] req_idx;
  assign req_in_range = {1'b0, in_ch.floor} < FLOOR_LIMIT;
  assign req_idx      = in_ch.floor[FIDX_W-1:0];

  // tick: pick a target. Up is evaluated first; a switch to down may load
  // on the same tick, a switch back to up waits for the next tick.
  logic              idle_t;
  logic              load_up, load_dn, load_any;
  logic [MODE_W-1:0] mode_t1, mode_t2;
  logic [FIDX_W-1:0] tgt, span;
  logic [SPF_W-1:0]  spf_eff;
  logic [TIME_W-1:0] prod, travel_t1;
  logic [FIDX_W-1:0] head_t1;

  always_comb begin
    idle_t  = (travel_r == '0);
    load_up = (mode_r == MODE_UP) && idle_t && (up_r != '0);
    mode_t1 = mode_r;
    if ((mode_r == MODE_UP) && idle_t && (up_r == '0)) begin
      mode_t1 = (down_r != '0) ? MODE_DOWN : MODE_STILL;
    end
    load_dn = (mode_t1 == MODE_DOWN) && idle_t && !load_up && (down_r != '0);
    mode_t2 = mode_t1;
    if ((mode_t1 == MODE_DOWN) && idle_t && (down_r == '0)) begin
      mode_t2 = (up_r != '0) ? MODE_UP : MODE_STILL;
    end
    load_any  = load_up || load_dn;
    tgt       = load_up ? lo_up : hi_dn;
    span      = (tgt > car_r) ? (tgt - car_r) : (car_r - tgt);
    spf_eff   = (spf_r == '0) ? SPF_W'(1) : spf_r;
    prod      = TIME_W'(spf_eff) * TIME_W'(span);
    travel_t1 = load_any ? prod : travel_r;
    head_t1   = load_any ? tgt : head_r;
  end

  // next state
  always_comb begin
    up_nxt     = up_r;
    down_nxt   = down_r;
    car_nxt    = car_r;
    head_nxt   = head_r;
    travel_nxt = travel_r;
    mode_nxt   = mode_r;
    res_nxt    = '0;
    unique case (in_ch.kind)
      KIND_PLACE: begin
        car_nxt    = req_in_range ? req_idx : TOP_FLOOR;
        head_nxt   = req_in_range ? req_idx : TOP_FLOOR;
        up_nxt     = '0;
        down_nxt   = '0;
        travel_nxt = '0;
        mode_nxt   = MODE_UP;
      end
      KIND_REQ: begin
        if (req_in_range) begin
          if (req_idx > car_r) begin
            up_nxt[req_idx] = 1'b1;
            if (mode_r != MODE_UP && mode_r != MODE_DOWN) mode_nxt = MODE_UP;
          end else if (req_idx < car_r) begin
            down_nxt[req_idx] = 1'b1;
            if (mode_r != MODE_UP && mode_r != MODE_DOWN) mode_nxt = MODE_DOWN;
          end
        end
      end
      KIND_TICK: begin
        mode_nxt   = mode_t2;
        head_nxt   = head_t1;
        travel_nxt = travel_t1;
        if (travel_t1 != '0) begin
          travel_nxt = travel_t1 - TIME_W'(1);
          if ((travel_t1 == TIME_W'(1)) && (mode_t2 == MODE_UP || mode_t2 == MODE_DOWN)) begin
            up_nxt[head_t1]   = 1'b0;
            down_nxt[head_t1] = 1'b0;
            car_nxt           = head_t1;
            res_nxt.arrived   = 1'b1;
          end
        end
      end
      default: begin
        // unknown kind: state unchanged, status reported
      end
    endcase
    res_nxt.direction     = (mode_nxt == MODE_UP || mode_nxt == MODE_DOWN) ? mode_nxt
                                                                           : MODE_STILL;
    res_nxt.target_floor  = FLOOR_W'(head_nxt);
    res_nxt.time_left     = travel_nxt;
    res_nxt.current_floor = FLOOR_W'(car_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      up_r        <= '0;
      down_r      <= '0;
      car_r       <= '0;
      head_r      <= '0;
      travel_r    <= '0;
      mode_r      <= MODE_UP;
      spf_r       <= SPF_RESET;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) spf_r <= cfg_wdata;
      if (in_acc) begin
        up_r        <= up_nxt;
        down_r      <= down_nxt;
        car_r       <= car_nxt;
        head_r      <= head_nxt;
        travel_r    <= travel_nxt;
        mode_r      <= mode_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // result payload, no reset needed
  always_ff @(posedge clk) begin
    if (in_acc) res_r <= res_nxt;
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.direction     = res_r.direction;
  assign out_ch.target_floor  = res_r.target_floor;
  assign out_ch.time_left     = res_r.time_left;
  assign out_ch.current_floor = res_r.current_floor;
  assign out_ch.arrived       = res_r.arrived;

  logic arr_at_tgt;
  logic mode_moving;
  assign arr_at_tgt  = (res_r.time_left == '0) && (res_r.current_floor == res_r.target_floor);
  assign mode_moving = (mode_r == MODE_UP) || (mode_r == MODE_DOWN);

  // arrival reports the car at its target with no travel left
  `ERS_ASSERT(a_arrive_at_target, out_valid_r && res_r.arrived |-> arr_at_tgt, "arrival off target")
  // travel only runs while moving up or down
  `ERS_ASSERT(a_travel_moving, (travel_r != '0) |-> mode_moving, "travel busy while still")
  // the car's own floor is never pending
  `ERS_ASSERT(a_car_not_pending, !up_r[car_r] && !down_r[car_r], "request pending at car floor")
  // an empty result register always takes a transaction
  `ERS_ASSERT(a_ready_when_empty, !out_valid_r |-> in_ch.ready, "stalled while empty")

endmodule

@@ tb/elevator_request_scheduler_core_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Elevator request scheduler core testbench
// Drives ticks, floor requests and placements through the input channel under
// random bursts and gaps. The result channel stalls on its own pattern. Every
// status transaction is checked against a cycle-free predictor of the car.
// ----------------------------------------------------------------------------
module elevator_request_scheduler_core_tb;
  import ers_pkg::*;

  // Kind code the block must ignore: it only reports the current status.
  localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;
  localparam int CAR_FLOORS     = NUM_FLOORS_DEF;
  localparam int QUIET_LIMIT    = 2000;  // cycles with no transaction at all
  localparam int TRAFFIC_PHASES = 6;
  localparam int PHASE_ITEMS    = 200;

  typedef struct packed {
    logic [KIND_W-1:0]  kind;
    logic [FLOOR_W-1:0] floor;
  } car_cmd_t;

  logic             clk;
  logic             rst_n;
  logic             cfg_we;
  logic [SPF_W-1:0] cfg_wdata;

  ers_req_if req_ch ();
  ers_rsp_if rsp_ch ();

  elevator_request_scheduler_core dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (req_ch),
    .out_ch   (rsp_ch),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  // Commands not yet accepted, and car status words still owed by the block.
  car_cmd_t cmd_q[$];
  result_t  status_q[$];

  int unsigned flaws;
  int unsigned quiet_cycles;
  bit          took_cmd;

  // ---------------------------------------------------------------------------
  // Predicted car state. Updated once per accepted input transaction.
  // ---------------------------------------------------------------------------
  logic [63:0]        up_calls;
  logic [63:0]        down_calls;
  logic [FLOOR_W-1:0] car_at;
  logic [FLOOR_W-1:0] bound_for;
  logic [TIME_W-1:0]  ticks_to_go;
  logic [MODE_W-1:0]  heading;
  logic [SPF_W-1:0]   spf_now;

  // Set a new target and load the travel counter. A zero rate counts as one.
  function automatic void start_trip(input int goal);
    int rate;
    int span;
    rate        = (spf_now == '0) ? 1 : int'(spf_now);
    span        = (goal > int'(car_at)) ? goal - int'(car_at) : int'(car_at) - goal;
    bound_for   = FLOOR_W'(goal);
    ticks_to_go = TIME_W'(rate * span);
  endfunction

  // Advance the car by one command and return the status it should report.
  function automatic result_t car_step(input logic [KIND_W-1:0] kind,
                                       input logic [FLOOR_W-1:0] fl);
    result_t st;
    logic    landed;
    int      pick;
    landed = 1'b0;
    pick   = 0;
    case (kind)
      KIND_PLACE: begin
        // placement saturates at the top floor when the shaft is shorter
        car_at      = (int'(fl) >= CAR_FLOORS) ? FLOOR_W'(CAR_FLOORS - 1) : fl;
        bound_for   = car_at;
        up_calls    = '0;
        down_calls  = '0;
        ticks_to_go = '0;
        heading     = MODE_UP;
      end
      KIND_REQ: begin
        // filed against the car's floor, even while it travels
        if (int'(fl) < CAR_FLOORS) begin
          if (fl > car_at) begin
            up_calls[fl] = 1'b1;
            if (heading != MODE_UP && heading != MODE_DOWN) heading = MODE_UP;
          end else if (fl < car_at) begin
            down_calls[fl] = 1'b1;
            if (heading != MODE_UP && heading != MODE_DOWN) heading = MODE_DOWN;
          end
        end
      end
      KIND_TICK: begin
        // up is resolved before down: up->down can load on this same tick,
        // down->up only turns around and loads on the next one
        if (heading == MODE_UP && ticks_to_go == '0) begin
          if (up_calls == '0) begin
            heading = (down_calls != '0) ? MODE_DOWN : MODE_STILL;
          end else begin
            for (int i = 63; i >= 0; i--) if (up_calls[i]) pick = i;
            start_trip(pick);
          end
        end
        if (heading == MODE_DOWN && ticks_to_go == '0) begin
          if (down_calls == '0) begin
            heading = (up_calls != '0) ? MODE_UP : MODE_STILL;
          end else begin
            for (int i = 0; i < 64; i++) if (down_calls[i]) pick = i;
            start_trip(pick);
          end
        end
        if (ticks_to_go != '0) begin
          ticks_to_go = ticks_to_go - 1'b1;
          if (ticks_to_go == '0 && (heading == MODE_UP || heading == MODE_DOWN)) begin
            up_calls[bound_for]   = 1'b0;
            down_calls[bound_for] = 1'b0;
            car_at                = bound_for;
            landed                = 1'b1;
          end
        end
      end
      default: ;  // unused kind: state untouched
    endcase
    st.direction     = (heading == MODE_UP || heading == MODE_DOWN) ? heading : MODE_STILL;
    st.target_floor  = bound_for;
    st.time_left     = ticks_to_go;
    st.current_floor = car_at;
    st.arrived       = landed;
    return st;
  endfunction

  // ---------------------------------------------------------------------------
  // Clock
  // ---------------------------------------------------------------------------
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Monitor: samples both channels at the rising edge, checks results against
  // the oldest predicted status, predicts new ones, and runs the watchdog.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : monitor
    result_t seen;
    result_t want;
    bit      got_status;
    if (rst_n) begin
      took_cmd   = req_ch.valid && req_ch.ready;
      got_status = rsp_ch.valid && rsp_ch.ready;
      // results are checked before this edge's command is predicted: the
      // status for a command accepted now cannot appear in the same cycle
      if (got_status) begin
        seen.direction     = rsp_ch.direction;
        seen.target_floor  = rsp_ch.target_floor;
        seen.time_left     = rsp_ch.time_left;
        seen.current_floor = rsp_ch.current_floor;
        seen.arrived       = rsp_ch.arrived;
        if (status_q.size() == 0) begin
          flaws++;
          if (flaws <= 10)
            $display("%0t: status transaction with none expected:", $realtime,
                     " dir=%0d tgt=%0d left=%0d cur=%0d arr=%0d",
                     seen.direction, seen.target_floor, seen.time_left,
                     seen.current_floor, seen.arrived);
        end else begin
          want = status_q.pop_front();
          if (seen !== want) begin
            flaws++;
            if (flaws <= 10)
              $display("%0t: status mismatch exp dir=%0d tgt=%0d left=%0d cur=%0d arr=%0d",
                       $realtime, want.direction, want.target_floor, want.time_left,
                       want.current_floor, want.arrived,
                       " / got dir=%0d tgt=%0d left=%0d cur=%0d arr=%0d",
                       seen.direction, seen.target_floor, seen.time_left,
                       seen.current_floor, seen.arrived);
          end
        end
      end
      if (took_cmd) begin
        status_q.insert(status_q.size(), car_step(req_ch.kind, req_ch.floor));
        cmd_q.delete(0);
      end
      // watchdog: only a run of cycles with no transaction on either side trips it
      if (took_cmd || got_status) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT) begin
          $display("elevator_request_scheduler_core verification failed");
          $finish;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Driver: changes inputs at the falling edge. Bursts of random length with
  // random gaps; a burst with no gaps at all comes up now and then. A command
  // on the bus is held until it is accepted.
  // ---------------------------------------------------------------------------
  int unsigned burst_left;
  int unsigned gap_left;
  int unsigned gap_len;

  always @(negedge clk) begin
    if (!rst_n) begin
      req_ch.valid <= 1'b0;
    end else if (req_ch.valid && !took_cmd) begin
      // stalled: keep the same transaction on the bus
    end else if (cmd_q.size() == 0) begin
      req_ch.valid <= 1'b0;
    end else if (gap_left != 0) begin
      gap_left--;
      req_ch.valid <= 1'b0;
    end else begin
      req_ch.valid <= 1'b1;
      req_ch.kind  <= cmd_q[0].kind;
      req_ch.floor <= cmd_q[0].floor;
      if (burst_left <= 1) begin
        burst_left = $urandom_range(1, 24);
        gap_len    = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        gap_left   = gap_len;
      end else begin
        burst_left--;
        gap_left = ($urandom_range(0, 2) == 0) ? gap_len : 0;
      end
    end
  end

  // Receiver: a repeating window, ready low for its first stall_len cycles.
  // Window shape is redrawn each time it wraps; some windows never stall.
  int unsigned win_pos;
  int unsigned win_len;
  int unsigned stall_len;

  always @(negedge clk) begin
    if (win_pos + 1 >= win_len) begin
      win_pos   = 0;
      win_len   = $urandom_range(4, 32);
      stall_len = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, win_len / 2);
    end else begin
      win_pos++;
    end
    rsp_ch.ready <= (win_pos >= stall_len);
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  function automatic void queue_cmd(input logic [KIND_W-1:0] kind, input int fl);
    car_cmd_t c;
    c.kind  = kind;
    c.floor = FLOOR_W'(fl);
    cmd_q.insert(cmd_q.size(), c);
  endfunction

  function automatic int clamp_floor(input int fl);
    return (fl < 0) ? 0 : (fl > 63) ? 63 : fl;
  endfunction

  // Random traffic around a home floor so trips stay short enough to finish,
  // with a share of requests anywhere in the shaft.
  function automatic void queue_traffic(input int n, input int home);
    int r;
    int fl;
    for (int k = 0; k < n; k++) begin
      r = $urandom_range(0, 99);
      if (r < 62) begin
        queue_cmd(KIND_TICK, $urandom_range(0, 63));
      end else if (r < 90) begin
        fl = ($urandom_range(0, 3) != 0) ? home + $urandom_range(0, 8) - 4
                                         : $urandom_range(0, 63);
        queue_cmd(KIND_REQ, clamp_floor(fl));
      end else if (r < 97) begin
        queue_cmd(KIND_PLACE, clamp_floor(home + $urandom_range(0, 4) - 2));
      end else begin
        queue_cmd(KIND_UNUSED, $urandom_range(0, 63));
      end
    end
  endfunction

  // Wait until every command is accepted and every status has come back.
  task automatic drain();
    while (cmd_q.size() != 0 || status_q.size() != 0) @(negedge clk);
    repeat (3) @(negedge clk);
  endtask

  // Register write, only issued while the block is idle.
  task automatic write_spf(input logic [SPF_W-1:0] v);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we  <= 1'b0;
    spf_now  = v;
  endtask

  initial begin
    int spf_pick;
    clk           = 1'b0;
    rst_n         = 1'b0;
    cfg_we        = 1'b0;
    cfg_wdata     = '0;
    req_ch.valid  = 1'b0;
    req_ch.kind   = KIND_TICK;
    req_ch.floor  = '0;
    rsp_ch.ready  = 1'b0;
    took_cmd      = 1'b0;
    flaws         = 0;
    quiet_cycles  = 0;
    burst_left    = 0;
    gap_left      = 0;
    gap_len       = 0;
    win_pos       = 0;
    win_len       = 0;
    stall_len     = 0;
    up_calls      = '0;
    down_calls    = '0;
    car_at        = '0;
    bound_for     = '0;
    ticks_to_go   = '0;
    heading       = MODE_UP;
    spf_now       = SPF_RESET;

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed part, at the reset rate of two ticks per floor.
    queue_cmd(KIND_TICK, 63);          // nothing pending: car goes still
    queue_cmd(KIND_REQ, 0);            // same floor as the car: dropped
    queue_cmd(KIND_REQ, 63);           // wakes the car going up
    queue_cmd(KIND_REQ, 5);
    queue_cmd(KIND_REQ, 5);            // duplicate merges
    queue_cmd(KIND_TICK, 0);           // lowest up target, 5
    queue_cmd(KIND_UNUSED, 63);        // ignored kind, status only
    queue_cmd(KIND_PLACE, 63);         // placement clears everything
    queue_cmd(KIND_REQ, 0);
    queue_cmd(KIND_TICK, 0);           // up empty: turns down and loads now
    queue_cmd(KIND_PLACE, 10);
    queue_cmd(KIND_REQ, 11);
    queue_cmd(KIND_REQ, 3);
    queue_cmd(KIND_TICK, 0);
    queue_cmd(KIND_TICK, 0);           // arrival at 11
    queue_cmd(KIND_TICK, 0);           // up to down on the same tick
    queue_cmd(KIND_REQ, 40);           // filed up while travelling down
    queue_cmd(KIND_PLACE, 0);
    queue_cmd(KIND_REQ, 1);
    queue_cmd(KIND_TICK, 0);
    queue_cmd(KIND_TICK, 0);           // arrival at 1
    queue_cmd(KIND_REQ, 0);            // down target while going up
    queue_cmd(KIND_TICK, 0);           // up empty: turns down, loads 0
    queue_cmd(KIND_REQ, 7);            // up request while heading down
    queue_cmd(KIND_TICK, 0);           // arrival at 0
    queue_cmd(KIND_TICK, 0);           // down empty: turns up, loads next tick
    queue_cmd(KIND_TICK, 0);
    drain();

    // Random phases, each at its own rate; the drain between them is also
    // the point where the sender holds off until all status has returned.
    for (int p = 0; p < TRAFFIC_PHASES; p++) begin
      case (p)
        0:       spf_pick = 0;     // zero rate behaves as one
        1:       spf_pick = 15;
        2:       spf_pick = 1;
        5:       spf_pick = 2;
        default: spf_pick = $urandom_range(3, 14);
      endcase
      write_spf(SPF_W'(spf_pick));
      queue_traffic(PHASE_ITEMS, $urandom_range(0, 63));
      drain();
    end

    if (flaws == 0 && status_q.size() == 0) begin
      $display("elevator_request_scheduler_core verification clean");
    end else begin
      $display("elevator_request_scheduler_core verification failed");
    end
    $finish;
  end

endmodule
